// ===== hw/rtl/u8san_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 sanitiser package
// Word types, job descriptor and lead-byte classification shared by the
// front end, the job queue and the emitter.
// ----------------------------------------------------------------------------
package u8san_pkg;

   // Default and width constants
   localparam int MAX_SEQ_BYTES_DEF = 6;
   localparam int QUEUE_DEPTH_DEF   = 2;
   localparam int SEQ_CNT_W         = 3;

   // Replacement character '?'
   localparam logic [7:0] QMARK = 8'h3F;

   // Lead-byte prefix masks and patterns
   localparam logic [7:0] MASK_1 = 8'h80;
   localparam logic [7:0] MASK_2 = 8'hC0;
   localparam logic [7:0] MASK_3 = 8'hE0;
   localparam logic [7:0] MASK_4 = 8'hF0;
   localparam logic [7:0] MASK_5 = 8'hF8;
   localparam logic [7:0] MASK_6 = 8'hFC;
   localparam logic [7:0] MASK_7 = 8'hFE;

   // Declared lengths; LEN_BAD means the byte is replaced on its own
   localparam logic [SEQ_CNT_W-1:0] LEN_BAD = 3'd0;
   localparam logic [SEQ_CNT_W-1:0] LEN_ONE = 3'd1;
   localparam logic [SEQ_CNT_W-1:0] LEN_TWO = 3'd2;
   localparam logic [SEQ_CNT_W-1:0] LEN_THR = 3'd3;
   localparam logic [SEQ_CNT_W-1:0] LEN_FOU = 3'd4;
   localparam logic [SEQ_CNT_W-1:0] LEN_FIV = 3'd5;
   localparam logic [SEQ_CNT_W-1:0] LEN_SIX = 3'd6;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       chunk_end;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       was_replaced;
      logic       run_last;
      logic       chunk_last;
   } rsp_word_type;

   // Control part of one queued job (the bytes travel beside it)
   typedef struct packed {
      logic [SEQ_CNT_W-1:0] count;
      logic                 bad;
      logic                 chunk_end;
   } job_info_type;

   // Sequence length declared by a lead byte
   function automatic logic [SEQ_CNT_W-1:0] lead_length(input logic [7:0] b);
      logic [SEQ_CNT_W-1:0] len;
      if ((b & MASK_1) == 8'h00)            len = LEN_ONE;
      else if ((b & MASK_2) == MASK_1)      len = LEN_BAD;
      else if ((b & MASK_3) == MASK_2)      len = LEN_TWO;
      else if ((b & MASK_4) == MASK_3)      len = LEN_THR;
      else if ((b & MASK_5) == MASK_4)      len = LEN_FOU;
      else if ((b & MASK_6) == MASK_5)      len = LEN_FIV;
      else if ((b & MASK_7) == MASK_6)      len = LEN_SIX;
      else                                  len = LEN_BAD;
      return len;
   endfunction

endpackage

// ===== hw/rtl/u8san_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 sanitiser front end
// Accepts one byte a cycle while the queue is not full, tracks the pending
// sequence and queues a finished job (bytes, count, replace flag, chunk end).
// ----------------------------------------------------------------------------
module u8san_front #(
   parameter int MAX_SEQ_BYTES = u8san_pkg::MAX_SEQ_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  u8san_pkg::req_word_type         req_data,
   input  logic                            job_full,
   output logic                            job_push,
   output logic [MAX_SEQ_BYTES-1:0][7:0]   job_bytes,
   output u8san_pkg::job_info_type         job_info
);
   import u8san_pkg::*;

   logic [MAX_SEQ_BYTES-1:0][7:0] held_ff, held_in;
   logic [SEQ_CNT_W-1:0]          exp_ff, exp_in;
   logic [SEQ_CNT_W-1:0]          seen_ff, seen_in;
   logic                          bad_ff, bad_in;

   logic                          accept;
   logic [7:0]                    b;
   logic [SEQ_CNT_W-1:0]          len;
   logic [SEQ_CNT_W-1:0]          seen_inc;
   logic                          new_bad;
   logic [MAX_SEQ_BYTES-1:0][7:0] merged;

   assign req_ready = !job_full;
   assign accept    = req_valid && req_ready;
   assign b         = req_data.data_byte;
   assign len       = lead_length(b);
   assign seen_inc  = seen_ff + SEQ_CNT_W'(1);
   assign new_bad   = bad_ff || (b[7:6] != 2'b10);

   // Held bytes with the incoming word placed at the next free slot
   always_comb begin
      merged = held_ff;
      for (int i = 0; i < MAX_SEQ_BYTES; i++) begin
         if (seen_ff == SEQ_CNT_W'(i)) merged[i] = b;
      end
   end

   // Classification and sequence tracking
   always_comb begin
      held_in             = held_ff;
      exp_in              = exp_ff;
      seen_in             = seen_ff;
      bad_in              = bad_ff;
      job_push            = 1'b0;
      job_bytes           = merged;
      job_info.count      = SEQ_CNT_W'(1);
      job_info.bad        = 1'b0;
      job_info.chunk_end  = req_data.chunk_end;
      if (accept) begin
         held_in = merged;
         if (exp_ff == LEN_BAD) begin
            if (len == LEN_ONE) begin
               job_push = 1'b1;
            end else if (len == LEN_BAD || len > SEQ_CNT_W'(MAX_SEQ_BYTES)) begin
               job_push     = 1'b1;
               job_info.bad = 1'b1;
            end else if (req_data.chunk_end) begin
               // lead byte is also the last of the chunk
               job_push     = 1'b1;
               job_info.bad = 1'b1;
            end else begin
               exp_in  = len;
               seen_in = SEQ_CNT_W'(1);
               bad_in  = 1'b0;
            end
         end else begin
            seen_in = seen_inc;
            bad_in  = new_bad;
            if (seen_inc >= exp_ff) begin
               job_push       = 1'b1;
               job_info.count = seen_inc;
               job_info.bad   = new_bad;
            end else if (req_data.chunk_end) begin
               // chunk cut the sequence short
               job_push       = 1'b1;
               job_info.count = seen_inc;
               job_info.bad   = 1'b1;
            end
            if (job_push) begin
               exp_in  = LEN_BAD;
               seen_in = '0;
               bad_in  = 1'b0;
            end
         end
      end
   end

   // Held bytes need no reset
   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff  <= LEN_BAD;
         seen_ff <= '0;
         bad_ff  <= 1'b0;
      end else begin
         exp_ff  <= exp_in;
         seen_ff <= seen_in;
         bad_ff  <= bad_in;
      end
   end

   // A pending sequence always has between one and expected-minus-one bytes
   a_pending_count: assert property (@(posedge clock) disable iff (reset)
      (exp_ff != LEN_BAD) |-> (seen_ff != '0 && seen_ff < exp_ff
                               && exp_ff <= SEQ_CNT_W'(MAX_SEQ_BYTES)))
      else $error("pending sequence count out of range");

endmodule

// ===== hw/rtl/u8san_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 sanitiser job queue
// Small register FIFO between the front end and the emitter.
// ----------------------------------------------------------------------------
module u8san_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = u8san_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             not_empty,
   output logic             full
);
   import u8san_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DEPTH-1:0][WIDTH-1:0] mem_ff, mem_in;
   logic [PTR_W-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]            count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_data = mem_ff[rd_ptr_ff];

   // Entry write, pointer and fill count update
   always_comb begin
      mem_in    = mem_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         mem_in[wr_ptr_ff] = push_data;
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop)      count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("job queue underflow");

endmodule

// ===== hw/rtl/u8san_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 sanitiser emitter
// Walks the head job one byte a cycle into the output register unless stalled.
// ----------------------------------------------------------------------------
module u8san_back #(
   parameter int MAX_SEQ_BYTES = u8san_pkg::MAX_SEQ_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            head_valid,
   input  logic [MAX_SEQ_BYTES-1:0][7:0]   head_bytes,
   input  u8san_pkg::job_info_type         head_info,
   output logic                            head_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output u8san_pkg::rsp_word_type         rsp_data
);
   import u8san_pkg::*;

   localparam int IDX_W = $clog2(MAX_SEQ_BYTES);

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_data_ff, rsp_data_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;

   logic                 advance;
   logic                 load;
   logic                 last;

   assign advance  = !rsp_valid_ff || rsp_ready;
   assign load     = advance && head_valid;
   assign last     = (SEQ_CNT_W'(idx_ff) + SEQ_CNT_W'(1)) == head_info.count;
   assign head_pop = load && last;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Next output word and byte index
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      idx_in       = idx_ff;
      if (advance) rsp_valid_in = head_valid;
      if (load) begin
         rsp_data_in.out_byte     = head_info.bad ? QMARK : head_bytes[idx_ff];
         rsp_data_in.was_replaced = head_info.bad;
         rsp_data_in.run_last     = last;
         rsp_data_in.chunk_last   = last && head_info.chunk_end;
         idx_in = last ? '0 : idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   a_chunk_on_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.chunk_last) |-> rsp_data_ff.run_last)
      else $error("chunk_last without run_last");

   a_replaced_is_qmark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.was_replaced) |-> (rsp_data_ff.out_byte == QMARK))
      else $error("replaced word is not the replacement character");

endmodule

// ===== hw/rtl/utf8_sequence_sanitizer.sv =====
`timescale 1ns / 1ps
// A word that completes a result group is taken and its job written into the job queue;
//   the emitter registers the group's first result word once the job reaches the queue
//   head; the rest of the group follows one word a cycle while rsp_ready is high.
// Throughput: one input word a cycle sustained. A word that leaves its sequence open yields
//   no result and the word that closes it yields the whole group (up to six), so over time
//   results match input words one for one. The input stalls while the two-entry job queue
//   is full, e.g. behind a long group or a stalled receiver.
// Reset clears the pending sequence, the queue and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
// UTF-8 sequence sanitiser
// Groups bytes into UTF-8 sequences and replaces malformed ones with '?'.
// ----------------------------------------------------------------------------
module utf8_sequence_sanitizer #(
   parameter int MAX_SEQ_BYTES = u8san_pkg::MAX_SEQ_BYTES_DEF,
   parameter int QUEUE_DEPTH   = u8san_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  u8san_pkg::req_word_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output u8san_pkg::rsp_word_type rsp_data
);
   import u8san_pkg::*;

   localparam int JOB_W = MAX_SEQ_BYTES * 8 + $bits(job_info_type);

   logic                          job_push;
   logic                          job_full;
   logic [MAX_SEQ_BYTES-1:0][7:0] job_bytes;
   job_info_type                  job_info;
   logic [JOB_W-1:0]              job_word;

   logic                          head_pop;
   logic                          head_valid;
   logic [JOB_W-1:0]              head_word;
   logic [MAX_SEQ_BYTES-1:0][7:0] head_bytes;
   job_info_type                  head_info;

   assign job_word   = {job_bytes, job_info};
   assign head_bytes = head_word[JOB_W-1:$bits(job_info_type)];
   assign head_info  = head_word[$bits(job_info_type)-1:0];

   u8san_front #(
      .MAX_SEQ_BYTES (MAX_SEQ_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_full  (job_full),
      .job_push  (job_push),
      .job_bytes (job_bytes),
      .job_info  (job_info)
   );

   u8san_queue #(
      .WIDTH (JOB_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_word),
      .pop       (head_pop),
      .head_data (head_word),
      .not_empty (head_valid),
      .full      (job_full)
   );

   u8san_back #(
      .MAX_SEQ_BYTES (MAX_SEQ_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_bytes (head_bytes),
      .head_info  (head_info),
      .head_pop   (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
